// File: sv/ppll_pkg.sv
// ppll_pkg: shared types, constants and small functions for the trio
// parentage log-likelihood core. No dependencies.
package ppll_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MAX_LOCI  = 1048576;

  localparam int unsigned GENO_W = 2;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned LL_W   = 48;
  localparam int unsigned CNT_W  = 21;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned ERR_W  = 18;  // error matrix entry, q0.17
  localparam int unsigned HW_W   = 33;  // hardy-weinberg entry, q0.32
  localparam int unsigned AB_W   = 32;  // a/b terms, q0.31
  localparam int unsigned T_W    = 20;  // transmission-weighted error, q0.19
  localparam int unsigned X_W    = 56;  // log argument
  localparam int unsigned V_W    = 64;  // normalizer
  localparam int unsigned MA_W   = 33;  // multiplier operand a
  localparam int unsigned MB_W   = 32;  // multiplier operand b
  localparam int unsigned MP_W   = MA_W + MB_W;
  localparam int unsigned LN_W   = 61;
  localparam int unsigned STEP_W = 5;

  localparam int unsigned LN_SHIFT = 54 - FRAC_BITS;
  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_LOCI < ((1 << CNT_W) - 1)) ? CNT_W'(MAX_LOCI) : CNT_W'((1 << CNT_W) - 1);

  localparam logic signed [LL_W-1:0] LL_MIN = {1'b1, {(LL_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_ERROR_HET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_HOM = 2'd1;

  localparam logic [5:0] FB_UNREL = 6'd49;
  localparam logic [5:0] FB_REL   = 6'd50;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_HW,
    OP_UMUL,
    OP_LOG_LOAD,
    OP_LOG_NORM,
    OP_LOG_SQ,
    OP_LOG_LN,
    OP_LOG_ADD,
    OP_REL_AB,
    OP_REL_PAB,
    OP_REL_PACC,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [1:0]        i;
    logic [1:0]        j;
    logic [STEP_W-1:0] step;
    logic              first;
    logic              rel;
  } dp_cmd_t;

  typedef struct packed {
    logic x_zero;
    logic big;
  } dp_stat_t;

  function automatic logic [1:0] geno_clamp(input logic [1:0] g);
    return (g == 2'd3) ? 2'd2 : g;
  endfunction

  // error matrix entry, row = true genotype, column = observed
  function automatic logic [ERR_W-1:0] err_val(input logic [1:0] row, input logic [1:0] col,
                                               input logic [RATE_W-1:0] eh,
                                               input logic [RATE_W-1:0] em);
    logic [ERR_W-1:0] rate;
    rate = (row == 2'd1) ? ERR_W'(eh) : ERR_W'(em);
    if (row == col) begin
      return ERR_W'(18'd131072 - (rate << 1));
    end
    return rate;
  endfunction

  // mendelian transmission in quarters
  function automatic logic [2:0] mendel_q(input logic [1:0] gm, input logic [1:0] gf,
                                          input logic [1:0] go);
    logic [1:0] hm;
    logic [1:0] hf;
    logic [2:0] r;
    hm = gm;
    hf = gf;
    r  = 3'd0;
    unique case ({hm, hf})
      {2'd0, 2'd0}: r = (go == 2'd0) ? 3'd4 : 3'd0;
      {2'd0, 2'd1}, {2'd1, 2'd0}: r = (go == 2'd2) ? 3'd0 : 3'd2;
      {2'd0, 2'd2}, {2'd2, 2'd0}: r = (go == 2'd1) ? 3'd4 : 3'd0;
      {2'd1, 2'd1}: r = (go == 2'd1) ? 3'd2 : 3'd1;
      {2'd1, 2'd2}, {2'd2, 2'd1}: r = (go == 2'd0) ? 3'd0 : 3'd2;
      {2'd2, 2'd2}: r = (go == 2'd2) ? 3'd4 : 3'd0;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/ppll_datapath.sv
// ppll_datapath: registers, shared multiplier and log unit of the core.
// Depends on ppll_pkg; driven by ppll_ctrl commands.
module ppll_datapath import ppll_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [RATE_W-1:0]        cfg_data_i,
  input  logic [GENO_W-1:0]        offspring_genotype_i,
  input  logic [GENO_W-1:0]        first_parent_genotype_i,
  input  logic [GENO_W-1:0]        second_parent_genotype_i,
  input  logic [FREQ_W-1:0]        allele_freq_i,
  output logic signed [LL_W-1:0]   ll_related_o,
  output logic signed [LL_W-1:0]   ll_unrelated_o,
  output logic [CNT_W-1:0]         loci_used_o,
  output logic                     log_floor_hit_o
);

  logic [RATE_W-1:0] eh_q, em_q;
  logic [1:0] go_q, p1_q, p2_q;
  logic [FREQ_W-1:0] q_q;
  logic [HW_W-1:0] h_q [3];
  logic [AB_W-1:0] ea_q [3];
  logic [AB_W-1:0] eb_q [3];
  logic [AB_W-1:0] ab_q;
  logic [X_W-1:0] x_q;
  logic [V_W-1:0] v_q;
  logic [5:0] z_q;
  logic zero_q;
  logic [30:0] m_q;
  logic [29:0] frac_q;
  logic [LN_W-1:0] ln_q;
  logic signed [LL_W-1:0] rel_sum_q, unr_sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic flag_q;
  logic signed [LL_W-1:0] out_rel_q, out_unr_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic out_flag_q;

  logic [16:0] nq;
  logic [1:0] col;
  logic [1:0] pcol;
  logic [T_W:0] t_sum;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_p;
  logic [5:0] fb;
  logic [5:0] kdiff;
  logic [35:0] mag;
  logic [30:0] msrc;
  logic [31:0] m2;
  logic [5:0] sh;
  logic topz;
  logic [LN_W-1:0] rnd;
  logic [LL_W-1:0] magr;
  logic signed [LL_W-1:0] term;
  logic signed [LL_W-1:0] sum_sel;
  logic signed [LL_W:0] sum_ext;
  logic signed [LL_W-1:0] sum_new;

  assign nq = 17'd65536 - 17'(q_q);
  assign fb = cmd_i.rel ? FB_REL : FB_UNREL;

  // observed column for the unrelated terms
  always_comb begin
    unique case (cmd_i.j)
      2'd0:    col = go_q;
      2'd1:    col = p1_q;
      default: col = p2_q;
    endcase
  end

  assign pcol = (cmd_i.j == 2'd0) ? p1_q : p2_q;

  always_comb begin
    t_sum = '0;
    for (int g = 0; g < 3; g++) begin
      t_sum = t_sum + (T_W+1)'(mendel_q(cmd_i.i, cmd_i.j, 2'(g))) *
                      (T_W+1)'(err_val(2'(g), go_q, eh_q, em_q));
    end
  end

  assign kdiff = 6'(7'(fb) + 7'(z_q) - 7'd63);
  assign mag   = {kdiff, 30'b0} - 36'(frac_q);
  assign msrc  = (cmd_i.step == '0) ? v_q[63:33] : m_q;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_HW: begin
        mul_a = (cmd_i.i == 2'd2) ? MA_W'(q_q) : MA_W'(nq);
        mul_b = (cmd_i.i == 2'd0) ? MB_W'(nq) : MB_W'(q_q);
      end
      OP_UMUL: begin
        mul_a = h_q[cmd_i.i];
        mul_b = MB_W'(err_val(cmd_i.i, col, eh_q, em_q));
      end
      OP_REL_AB: begin
        mul_a = h_q[cmd_i.i];
        mul_b = MB_W'(err_val(cmd_i.i, pcol, eh_q, em_q));
      end
      OP_REL_PAB: begin
        mul_a = MA_W'(ea_q[cmd_i.i]);
        mul_b = eb_q[cmd_i.j];
      end
      OP_REL_PACC: begin
        mul_a = MA_W'(ab_q);
        mul_b = MB_W'(t_sum);
      end
      OP_LOG_SQ: begin
        mul_a = MA_W'(msrc);
        mul_b = MB_W'(msrc);
      end
      OP_LOG_LN: begin
        mul_a = (cmd_i.i == 2'd0) ? MA_W'(mag[17:0]) : MA_W'(mag[35:18]);
        mul_b = MB_W'(LN2_Q24);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign m2    = mul_p[61:30];

  // binary search for the leading one, one step per cycle
  always_comb begin
    sh   = 6'd0;
    topz = 1'b0;
    unique case (cmd_i.step[2:0])
      3'd0: begin sh = 6'd32; topz = (v_q[63:32] == '0); end
      3'd1: begin sh = 6'd16; topz = (v_q[63:48] == '0); end
      3'd2: begin sh = 6'd8;  topz = (v_q[63:56] == '0); end
      3'd3: begin sh = 6'd4;  topz = (v_q[63:60] == '0); end
      3'd4: begin sh = 6'd2;  topz = (v_q[63:62] == '0); end
      3'd5: begin sh = 6'd1;  topz = ~v_q[63]; end
      default: begin sh = 6'd0; topz = 1'b0; end
    endcase
  end

  assign rnd  = ln_q + (LN_W'(1) << (LN_SHIFT - 1));
  assign magr = LL_W'(rnd >> LN_SHIFT);

  always_comb begin
    if (zero_q) begin
      term = LL_MIN;
    end else if (stat_o.big) begin
      term = '0;
    end else begin
      term = $signed(LL_W'(0) - magr);
    end
  end

  assign sum_sel = cmd_i.rel ? rel_sum_q : unr_sum_q;
  assign sum_ext = {sum_sel[LL_W-1], sum_sel} + {term[LL_W-1], term};
  assign sum_new = (sum_ext < $signed({LL_MIN[LL_W-1], LL_MIN})) ? LL_MIN
                                                                 : sum_ext[LL_W-1:0];

  assign stat_o.x_zero = (x_q == '0);
  assign stat_o.big    = ((6'd63 - z_q) >= fb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eh_q <= '0;
      em_q <= '0;
      rel_sum_q <= '0;
      unr_sum_q <= '0;
      cnt_q <= '0;
      flag_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ERROR_HET) begin
          eh_q <= cfg_data_i;
        end else if (cfg_index_i == REG_ERROR_HOM) begin
          em_q <= cfg_data_i;
        end
      end
      if (cmd_i.op == OP_LOG_ADD) begin
        if (zero_q) begin
          flag_q <= 1'b1;
        end
        if (cmd_i.rel) begin
          rel_sum_q <= sum_new;
          if (cnt_q < CNT_CAP) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end else begin
          unr_sum_q <= sum_new;
        end
      end else if (cmd_i.op == OP_EMIT) begin
        rel_sum_q <= '0;
        unr_sum_q <= '0;
        cnt_q <= '0;
        flag_q <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        go_q <= geno_clamp(offspring_genotype_i);
        p1_q <= geno_clamp(first_parent_genotype_i);
        p2_q <= geno_clamp(second_parent_genotype_i);
        q_q  <= allele_freq_i;
      end
      OP_HW: begin
        h_q[cmd_i.i] <= (cmd_i.i == 2'd1) ? HW_W'(mul_p << 1) : HW_W'(mul_p);
      end
      OP_UMUL: begin
        x_q <= (cmd_i.first ? X_W'(0) : x_q) + X_W'(mul_p[49:0]);
      end
      OP_REL_AB: begin
        if (cmd_i.j == 2'd0) begin
          ea_q[cmd_i.i] <= mul_p[49:18];
        end else begin
          eb_q[cmd_i.i] <= mul_p[49:18];
        end
      end
      OP_REL_PAB: begin
        ab_q <= mul_p[62:31];
      end
      OP_REL_PACC: begin
        x_q <= (cmd_i.first ? X_W'(0) : x_q) + mul_p[55:0];
      end
      OP_LOG_LOAD: begin
        v_q    <= V_W'(x_q);
        z_q    <= '0;
        zero_q <= (x_q == '0);
      end
      OP_LOG_NORM: begin
        if (topz) begin
          v_q <= v_q << sh;
          z_q <= z_q + sh;
        end
      end
      OP_LOG_SQ: begin
        if (m2[31]) begin
          m_q <= m2[31:1];
        end else begin
          m_q <= m2[30:0];
        end
        frac_q <= ((cmd_i.step == '0) ? 30'd0 : frac_q) |
                  (30'(m2[31]) << (5'd29 - cmd_i.step));
      end
      OP_LOG_LN: begin
        if (cmd_i.i == 2'd0) begin
          ln_q <= mul_p[LN_W-1:0];
        end else begin
          ln_q <= ln_q + LN_W'({mul_p[42:0], 18'b0});
        end
      end
      OP_EMIT: begin
        out_rel_q  <= rel_sum_q;
        out_unr_q  <= unr_sum_q;
        out_cnt_q  <= cnt_q;
        out_flag_q <= flag_q;
      end
      default: begin
      end
    endcase
  end

  assign ll_related_o    = out_rel_q;
  assign ll_unrelated_o  = out_unr_q;
  assign loci_used_o     = out_cnt_q;
  assign log_floor_hit_o = out_flag_q;

endmodule

// File: sv/ppll_ctrl.sv
// ppll_ctrl: sequencer for the trio parentage core; issues datapath commands
// and runs the input and output handshakes. Depends on ppll_pkg.
module ppll_ctrl import ppll_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     offspring_missing_i,
  input  logic     last_locus_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_HW     = 12'b000000000010,
    S_UMUL   = 12'b000000000100,
    S_LNLOAD = 12'b000000001000,
    S_LNNORM = 12'b000000010000,
    S_LNSQ   = 12'b000000100000,
    S_LNMUL  = 12'b000001000000,
    S_LNADD  = 12'b000010000000,
    S_RAB    = 12'b000100000000,
    S_RPAB   = 12'b001000000000,
    S_RPACC  = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [1:0] i_q, i_d, j_q, j_d, uk_q, uk_d;
  logic rel_q, rel_d, last_q, last_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    uk_d        = uk_q;
    rel_d       = rel_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '{op: OP_NONE, i: 2'd0, j: 2'd0, step: '0, first: 1'b0, rel: rel_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          last_d   = last_locus_i;
          cnt_d    = '0;
          if (offspring_missing_i) begin
            state_d = last_locus_i ? S_EMIT : S_IDLE;
          end else begin
            state_d = S_HW;
          end
        end
      end
      S_HW: begin
        cmd_o.op = OP_HW;
        cmd_o.i  = cnt_q[1:0];
        if (cnt_q == STEP_W'(2)) begin
          cnt_d   = '0;
          uk_d    = 2'd0;
          state_d = S_UMUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_UMUL: begin
        cmd_o.op    = OP_UMUL;
        cmd_o.i     = cnt_q[1:0];
        cmd_o.j     = uk_q;
        cmd_o.first = (cnt_q == '0);
        if (cnt_q == STEP_W'(2)) begin
          rel_d   = 1'b0;
          state_d = S_LNLOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LNLOAD: begin
        cmd_o.op = OP_LOG_LOAD;
        cnt_d    = '0;
        state_d  = stat_i.x_zero ? S_LNADD : S_LNNORM;
      end
      S_LNNORM: begin
        cmd_o.op   = OP_LOG_NORM;
        cmd_o.step = cnt_q;
        if (cnt_q == STEP_W'(5)) begin
          cnt_d   = '0;
          state_d = S_LNSQ;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LNSQ: begin
        // argument at or above one: the log is zero
        if (stat_i.big) begin
          state_d = S_LNADD;
        end else begin
          cmd_o.op   = OP_LOG_SQ;
          cmd_o.step = cnt_q;
          if (cnt_q == STEP_W'(29)) begin
            cnt_d   = '0;
            state_d = S_LNMUL;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_LNMUL: begin
        cmd_o.op = OP_LOG_LN;
        cmd_o.i  = {1'b0, cnt_q[0]};
        if (cnt_q[0]) begin
          state_d = S_LNADD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LNADD: begin
        cmd_o.op = OP_LOG_ADD;
        cnt_d    = '0;
        if (rel_q) begin
          state_d = last_q ? S_EMIT : S_IDLE;
        end else if (uk_q == 2'd2) begin
          i_d     = 2'd0;
          j_d     = 2'd0;
          state_d = S_RAB;
        end else begin
          uk_d    = uk_q + 1'b1;
          state_d = S_UMUL;
        end
      end
      S_RAB: begin
        cmd_o.op = OP_REL_AB;
        cmd_o.i  = i_q;
        cmd_o.j  = j_q;
        if (i_q == 2'd2) begin
          i_d = 2'd0;
          if (j_q == 2'd1) begin
            j_d     = 2'd0;
            state_d = S_RPAB;
          end else begin
            j_d = 2'd1;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_RPAB: begin
        cmd_o.op = OP_REL_PAB;
        cmd_o.i  = i_q;
        cmd_o.j  = j_q;
        state_d  = S_RPACC;
      end
      S_RPACC: begin
        cmd_o.op    = OP_REL_PACC;
        cmd_o.i     = i_q;
        cmd_o.j     = j_q;
        cmd_o.first = (i_q == 2'd0) && (j_q == 2'd0);
        if (j_q == 2'd2) begin
          j_d = 2'd0;
          if (i_q == 2'd2) begin
            i_d     = 2'd0;
            rel_d   = 1'b1;
            state_d = S_LNLOAD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_RPAB;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RPAB;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      uk_q        <= '0;
      rel_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      uk_q        <= uk_d;
      rel_q       <= rel_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LNADD && rel_q && last_q) |=> (state_q == S_EMIT))
    else $error("last locus did not lead to a result");
  a_rel_after_unrel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RAB) |-> (uk_q == 2'd2 && !rel_q))
    else $error("related pass started before three unrelated terms");
`endif

endmodule

// File: sv/parent_pair_log_likelihood_core.sv
// parent_pair_log_likelihood_core: top level of the trio parentage core.
// Depends on ppll_pkg, ppll_ctrl and ppll_datapath.
//
// takes one locus word per accepted input (offspring and two candidate parent
// genotypes, missing flag, alternate allele frequency in q0.16, last flag) and
// accumulates a related and an unrelated log-likelihood in signed q31.16,
// saturating at -2^47; on a word with last_locus set one result word carries
// both sums, the count of non-missing loci and the log-of-zero flag, and the
// sums are cleared. one multiplier serves all but the transmission-sum
// products; the log unit (6 normalize steps, 30 squaring steps, 2 scale steps)
// reuses it. a non-missing locus runs every step (fewer when a log argument is
// zero or at least one), a missing locus its load step alone, and an emit step
// loads the result register. input is taken only while the sequencer is idle;
// the result register lets the next locus start while a result still waits.
// error rates are written through the cfg port (index 0 het, 1 hom) by the
// user only while the block is idle (not enforced); the port is always ready.
module parent_pair_log_likelihood_core import ppll_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // locus words
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [GENO_W-1:0]      offspring_genotype_i,
  input  logic [GENO_W-1:0]      first_parent_genotype_i,
  input  logic [GENO_W-1:0]      second_parent_genotype_i,
  input  logic                   offspring_missing_i,
  input  logic [FREQ_W-1:0]      allele_freq_i,
  input  logic                   last_locus_i,
  // result words
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [LL_W-1:0] ll_related_o,
  output logic signed [LL_W-1:0] ll_unrelated_o,
  output logic [CNT_W-1:0]       loci_used_o,
  output logic                   log_floor_hit_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [RATE_W-1:0]      cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register file never blocks a write
  assign cfg_ready_o = 1'b1;

  ppll_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .offspring_missing_i (offspring_missing_i),
    .last_locus_i        (last_locus_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cmd_o               (cmd),
    .stat_i              (stat)
  );

  ppll_datapath u_datapath (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_i                    (cmd),
    .stat_o                   (stat),
    .cfg_we_i                 (cfg_valid_i && cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i),
    .offspring_genotype_i     (offspring_genotype_i),
    .first_parent_genotype_i  (first_parent_genotype_i),
    .second_parent_genotype_i (second_parent_genotype_i),
    .allele_freq_i            (allele_freq_i),
    .ll_related_o             (ll_related_o),
    .ll_unrelated_o           (ll_unrelated_o),
    .loci_used_o              (loci_used_o),
    .log_floor_hit_o          (log_floor_hit_o)
  );

endmodule

// File: sim/ppll_checker.sv
// ppll_checker: watches the locus, result and cfg channels of the trio core,
// keeps its own likelihood sums and compares every result word. Uses ppll_pkg.
module ppll_checker import ppll_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [GENO_W-1:0]      offspring_genotype_i,
  input  logic [GENO_W-1:0]      first_parent_genotype_i,
  input  logic [GENO_W-1:0]      second_parent_genotype_i,
  input  logic                   offspring_missing_i,
  input  logic [FREQ_W-1:0]      allele_freq_i,
  input  logic                   last_locus_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [LL_W-1:0] ll_related_i,
  input  logic signed [LL_W-1:0] ll_unrelated_i,
  input  logic [CNT_W-1:0]       loci_used_i,
  input  logic                   log_floor_hit_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [RATE_W-1:0]      cfg_data_i,
  output int                     mismatches_o,
  output int                     sums_waiting_o
);

  typedef struct packed {
    logic signed [LL_W-1:0] rel;
    logic signed [LL_W-1:0] unrel;
    logic [CNT_W-1:0]       used;
    logic                   floor_hit;
  } trio_sums_t;

  // expected result words in order, a small ring
  trio_sums_t     exp_ring [16];
  logic [3:0]     wr_ptr, rd_ptr;
  int             fill;
  logic [15:0]    rate_het, rate_hom;
  longint signed  rel_acc, unrel_acc;
  int unsigned    used_acc;
  bit             floor_acc;

  assign sums_waiting_o = fill;

  // natural log of x / 2^fb, non-positive, q.16
  function automatic longint signed ln_fixed(longint unsigned x, int unsigned fb);
    int unsigned    k;
    longint unsigned m, frac, mag;
    k = 0;
    frac = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    if (k >= fb) return 0;
    m = (k > 30) ? (x >> (k - 30)) : (x << (30 - k));
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac |= 64'd1 << (29 - i);
      end
    end
    mag = (longint'(fb - k) << 30) - frac;
    mag = (mag * 64'd11629080 + (64'd1 << 37)) >> 38;
    return -longint'(mag);
  endfunction

  function automatic longint signed ll_add(longint signed s, longint unsigned x,
                                           int unsigned fb, ref bit flag);
    longint signed t, v;
    if (x == 0) begin
      flag = 1;
      t = -(64'sd1 <<< 47);
    end else begin
      t = ln_fixed(x, fb);
    end
    v = s + t;
    return (v < -(64'sd1 <<< 47)) ? -(64'sd1 <<< 47) : v;
  endfunction

  function automatic int unsigned g_clamp(logic [1:0] g);
    return (g == 2'd3) ? 2 : int'(g);
  endfunction

  function automatic int unsigned transmit_q(int unsigned gm, int unsigned gf, int unsigned go);
    int unsigned tab[27] = '{4,0,0, 2,2,0, 0,4,0,  2,2,0, 1,2,1, 0,2,2,  0,4,0, 0,2,2, 0,0,4};
    return tab[gm*9 + gf*3 + go];
  endfunction

  task automatic accumulate_locus();
    longint unsigned h[3], e[3][3], hwe[3], a[3], b[3], p, t, q, nq;
    int unsigned     go, p1, p2;
    go = g_clamp(offspring_genotype_i);
    p1 = g_clamp(first_parent_genotype_i);
    p2 = g_clamp(second_parent_genotype_i);
    if (!offspring_missing_i) begin
      q  = allele_freq_i;
      nq = 65536 - q;
      h[0] = nq * nq;
      h[1] = 2 * q * nq;
      h[2] = q * q;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          longint unsigned rt;
          rt = (r == 1) ? rate_het : rate_hom;
          e[r][c] = (r == c) ? 2 * (65536 - rt) : rt;
        end
      for (int j = 0; j < 3; j++) begin
        hwe[j] = 0;
        for (int i = 0; i < 3; i++) hwe[j] += h[i] * e[i][j];
      end
      unrel_acc = ll_add(unrel_acc, hwe[go], 49, floor_acc);
      unrel_acc = ll_add(unrel_acc, hwe[p1], 49, floor_acc);
      unrel_acc = ll_add(unrel_acc, hwe[p2], 49, floor_acc);
      for (int i = 0; i < 3; i++) begin
        a[i] = (h[i] * e[i][p1]) >> 18;
        b[i] = (h[i] * e[i][p2]) >> 18;
      end
      p = 0;
      for (int gm = 0; gm < 3; gm++)
        for (int gf = 0; gf < 3; gf++) begin
          t = 0;
          for (int g = 0; g < 3; g++) t += transmit_q(gm, gf, g) * e[g][go];
          p += ((a[gm] * b[gf]) >> 31) * t;
        end
      rel_acc = ll_add(rel_acc, p, 50, floor_acc);
      if (used_acc < CNT_CAP) used_acc++;
    end
    if (last_locus_i) begin
      exp_ring[wr_ptr] = '{rel: rel_acc[LL_W-1:0], unrel: unrel_acc[LL_W-1:0],
                           used: used_acc[CNT_W-1:0], floor_hit: floor_acc};
      wr_ptr = wr_ptr + 4'd1;
      fill++;
      rel_acc = 0;
      unrel_acc = 0;
      used_acc = 0;
      floor_acc = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_het = '0;
      rate_hom = '0;
      rel_acc = 0;
      unrel_acc = 0;
      used_acc = 0;
      floor_acc = 0;
      mismatches_o = 0;
      wr_ptr = '0;
      rd_ptr = '0;
      fill = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ERROR_HET) rate_het = cfg_data_i;
        else if (cfg_index_i == REG_ERROR_HOM) rate_hom = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (fill == 0) begin
          $display("%0t: result word with nothing expected: rel %0d unrel %0d",
                   $time, ll_related_i, ll_unrelated_i);
          mismatches_o++;
        end else begin
          trio_sums_t exp_w;
          exp_w = exp_ring[rd_ptr];
          rd_ptr = rd_ptr + 4'd1;
          fill--;
          if (ll_related_i !== exp_w.rel) begin
            $display("%0t: ll_related expected %0d actual %0d", $time, exp_w.rel, ll_related_i);
            mismatches_o++;
          end
          if (ll_unrelated_i !== exp_w.unrel) begin
            $display("%0t: ll_unrelated expected %0d actual %0d", $time, exp_w.unrel,
                     ll_unrelated_i);
            mismatches_o++;
          end
          if (loci_used_i !== exp_w.used) begin
            $display("%0t: loci_used expected %0d actual %0d", $time, exp_w.used, loci_used_i);
            mismatches_o++;
          end
          if (log_floor_hit_i !== exp_w.floor_hit) begin
            $display("%0t: log_floor_hit expected %0d actual %0d", $time, exp_w.floor_hit,
                     log_floor_hit_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) accumulate_locus();
    end
  end

endmodule

// File: sim/tb_top.sv
// tb_top: stimulus and verdict for parent_pair_log_likelihood_core.
// Depends on ppll_pkg, the core and ppll_checker.
module tb_top;
  import ppll_pkg::*;

  logic                   clk_i, rst_ni;
  logic                   in_valid, in_stall;
  logic [GENO_W-1:0]      off_g, par1_g, par2_g;
  logic                   off_missing, last_locus;
  logic [FREQ_W-1:0]      freq;
  logic                   out_valid, out_stall;
  logic signed [LL_W-1:0] ll_rel, ll_unrel;
  logic [CNT_W-1:0]       used;
  logic                   floor_hit;
  logic                   cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [RATE_W-1:0]      cfg_data;
  int                     mismatches, sums_waiting;
  bit                     quiet;     // no idling on either side
  int                     stall_left;

  parent_pair_log_likelihood_core dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .offspring_genotype_i(off_g), .first_parent_genotype_i(par1_g),
    .second_parent_genotype_i(par2_g), .offspring_missing_i(off_missing),
    .allele_freq_i(freq), .last_locus_i(last_locus),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .ll_related_o(ll_rel), .ll_unrelated_o(ll_unrel),
    .loci_used_o(used), .log_floor_hit_o(floor_hit),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // checker sits beside the core and sees only its ports
  ppll_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .offspring_genotype_i(off_g), .first_parent_genotype_i(par1_g),
    .second_parent_genotype_i(par2_g), .offspring_missing_i(off_missing),
    .allele_freq_i(freq), .last_locus_i(last_locus),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .ll_related_i(ll_rel), .ll_unrelated_i(ll_unrel),
    .loci_used_i(used), .log_floor_hit_i(floor_hit),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .sums_waiting_o(sums_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure: random bursts of stalled cycles
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // send one locus word; valid stays high between back-to-back words
  task automatic send_locus(logic [1:0] go, logic [1:0] g1, logic [1:0] g2,
                            logic miss, logic [15:0] q, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    off_g       <= go;
    par1_g      <= g1;
    par2_g      <= g2;
    off_missing <= miss;
    freq        <= q;
    last_locus  <= last;
    // stall only moves on rising edges, so look at it mid-cycle
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sums_waiting != 0) @(posedge clk_i);
    // a trailing non-last locus may still be in the log unit
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_freq();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 200));
      default: return 16'($urandom);
    endcase
  endfunction

  // one pedigree scan: random loci, closed by a last-locus word
  task automatic random_scan(int n);
    for (int i = 0; i < n; i++)
      send_locus(2'($urandom), 2'($urandom), 2'($urandom), $urandom_range(0, 7) == 0,
                 rand_freq(), i == n - 1);
  endtask

  task automatic random_phase(int n_loci);
    int sent, len;
    sent = 0;
    while (sent < n_loci) begin
      len = $urandom_range(1, 20);
      random_scan(len);
      sent += len;
    end
  endtask

  logic [15:0] het_set[7] = '{16'd0, 16'hFFFF, 16'd0,    16'hFFFF, 16'd655, 16'd0, 16'd0};
  logic [15:0] hom_set[7] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0,    16'd1311, 16'd0, 16'd0};

  initial begin
    quiet       = 1'b0;
    in_valid    = 1'b0;
    off_g       = '0;
    par1_g      = '0;
    par2_g      = '0;
    off_missing = 1'b0;
    freq        = '0;
    last_locus  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ERROR_HET;
    cfg_data    = '0;
    het_set[5]  = 16'($urandom);
    hom_set[5]  = 16'($urandom);
    het_set[6]  = 16'($urandom_range(1, 3000));
    hom_set[6]  = 16'($urandom_range(1, 3000));
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero error rates after reset
    send_locus(2'd0, 2'd0, 2'd0, 1'b0, 16'd32768, 1'b1);  // single-locus scan
    send_locus(2'd2, 2'd2, 2'd2, 1'b0, 16'hFFFF, 1'b0);
    send_locus(2'd1, 2'd0, 2'd2, 1'b0, 16'd1, 1'b0);
    send_locus(2'd3, 2'd3, 2'd3, 1'b0, 16'd40000, 1'b1);  // code 3 reads as alt/alt
    send_locus(2'd2, 2'd0, 2'd0, 1'b0, 16'd0, 1'b1);      // log of zero, floor flag
    send_locus(2'd0, 2'd2, 2'd2, 1'b0, 16'd0, 1'b0);
    send_locus(2'd1, 2'd1, 2'd1, 1'b1, 16'd12345, 1'b1);  // missing offspring on last
    send_locus(2'd1, 2'd1, 2'd1, 1'b1, 16'd0, 1'b1);      // all-missing scan
    send_locus(2'd1, 2'd1, 2'd0, 1'b0, 16'hFFFF, 1'b0);
    send_locus(2'd0, 2'd1, 2'd2, 1'b0, 16'd100, 1'b0);
    send_locus(2'd2, 2'd1, 2'd1, 1'b1, 16'd5, 1'b0);
    send_locus(2'd1, 2'd2, 2'd1, 1'b0, 16'd20000, 1'b1);
    // repeated floor hits drive both sums into saturation
    for (int i = 0; i < 6; i++)
      send_locus(2'd2, 2'd2, 2'd0, 1'b0, 16'd0, i == 5);
    wait_idle();

    // max error rates: diagonal terms nearly vanish
    write_rate(REG_ERROR_HET, 16'hFFFF);
    write_rate(REG_ERROR_HOM, 16'hFFFF);
    send_locus(2'd0, 2'd0, 2'd0, 1'b0, 16'd0, 1'b0);
    send_locus(2'd1, 2'd1, 2'd1, 1'b0, 16'd32768, 1'b0);
    send_locus(2'd2, 2'd0, 2'd2, 1'b0, 16'hFFFF, 1'b1);
    wait_idle();

    // random scans over a sweep of error-rate settings
    for (int s = 0; s < 7; s++) begin
      write_rate(REG_ERROR_HOM, hom_set[s]);
      write_rate(REG_ERROR_HET, het_set[s]);
      if (s == 6) quiet = 1'b1;  // closing stretch runs at full rate
      random_phase(s == 6 ? 200 : 175);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
sv/ppll_pkg.sv
sv/ppll_datapath.sv
sv/ppll_ctrl.sv
sv/parent_pair_log_likelihood_core.sv
sim/ppll_checker.sv
sim/tb_top.sv
